// ----- hw/rtl/qrvu_pkg.sv -----
// qrvu_pkg: shared types, constants and tables for the quaternion rotation vector update
// no dependencies
`default_nettype none

package qrvu_pkg;

   localparam int WORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS      = 30;
   localparam int CORDIC_ITERS   = 30;
   localparam int CORDIC_W       = 36;
   localparam int INC_W          = 33;
   localparam int STEP_W         = 5;

   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 36'sd652032874;
   localparam logic signed [CORDIC_W-1:0] PI_Q30      = 36'sd3373259426;
   localparam logic signed [CORDIC_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [CORDIC_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
   localparam logic signed [INC_W-1:0]    ONE_Q30     = 33'sd1073741824;

   typedef enum logic {
      OP_APPLY = 1'b0,
      OP_LOAD  = 1'b1
   } op_type;

   typedef struct packed {
      logic              start;
      logic              load;
      logic              sumsq;
      logic              sqrt_step;
      logic              div_init;
      logic              divc_step;
      logic              inc_zero;
      logic              inc_set;
      logic              mul_go;
      logic              mul_quat;
      logic              commit;
      logic              out_load;
      logic [STEP_W-1:0] step;
   } cmd_type;

   typedef struct packed {
      logic angle_zero;
   } status_type;

   // one product of the quaternion multiply: attitude word, increment word, sign
   typedef struct packed {
      logic [1:0] att;
      logic [1:0] inc;
      logic       neg;
   } term_type;

   function automatic term_type qr_term(input logic [3:0] k);
      term_type t;
      unique case (k)
         4'd0:  t = '{att: 2'd0, inc: 2'd0, neg: 1'b0};
         4'd1:  t = '{att: 2'd1, inc: 2'd1, neg: 1'b1};
         4'd2:  t = '{att: 2'd2, inc: 2'd2, neg: 1'b1};
         4'd3:  t = '{att: 2'd3, inc: 2'd3, neg: 1'b1};
         4'd4:  t = '{att: 2'd1, inc: 2'd0, neg: 1'b0};
         4'd5:  t = '{att: 2'd0, inc: 2'd1, neg: 1'b0};
         4'd6:  t = '{att: 2'd3, inc: 2'd2, neg: 1'b0};
         4'd7:  t = '{att: 2'd2, inc: 2'd3, neg: 1'b1};
         4'd8:  t = '{att: 2'd2, inc: 2'd0, neg: 1'b0};
         4'd9:  t = '{att: 2'd0, inc: 2'd2, neg: 1'b0};
         4'd10: t = '{att: 2'd1, inc: 2'd3, neg: 1'b0};
         4'd11: t = '{att: 2'd3, inc: 2'd1, neg: 1'b1};
         4'd12: t = '{att: 2'd3, inc: 2'd0, neg: 1'b0};
         4'd13: t = '{att: 2'd0, inc: 2'd3, neg: 1'b0};
         4'd14: t = '{att: 2'd2, inc: 2'd1, neg: 1'b0};
         4'd15: t = '{att: 2'd1, inc: 2'd2, neg: 1'b1};
         default: t = '{att: 2'd0, inc: 2'd0, neg: 1'b0};
      endcase
      return t;
   endfunction

   function automatic logic signed [CORDIC_W-1:0] atan_q30(input logic [STEP_W-1:0] i);
      logic signed [CORDIC_W-1:0] a;
      unique case (i)
         5'd0:  a = 36'sh03243F6A8;
         5'd1:  a = 36'sh01DAC6705;
         5'd2:  a = 36'sh00FADBAFC;
         5'd3:  a = 36'sh007F56EA6;
         5'd4:  a = 36'sh003FEAB76;
         5'd5:  a = 36'sh001FFD55B;
         5'd6:  a = 36'sh000FFFAAA;
         5'd7:  a = 36'sh0007FFF55;
         5'd8:  a = 36'sh0003FFFEA;
         5'd9:  a = 36'sh0001FFFFD;
         5'd10: a = 36'sh0000FFFFF;
         5'd11: a = 36'sh00007FFFF;
         5'd12: a = 36'sh00003FFFF;
         5'd13: a = 36'sh00001FFFF;
         5'd14: a = 36'sh00000FFFF;
         5'd15: a = 36'sh000007FFF;
         5'd16: a = 36'sh000003FFF;
         5'd17: a = 36'sh000001FFF;
         5'd18: a = 36'sh000000FFF;
         5'd19: a = 36'sh0000007FF;
         5'd20: a = 36'sh0000003FF;
         5'd21: a = 36'sh0000001FF;
         5'd22: a = 36'sh0000000FF;
         5'd23: a = 36'sh00000007F;
         5'd24: a = 36'sh00000003F;
         5'd25: a = 36'sh00000001F;
         5'd26: a = 36'sh00000000F;
         5'd27: a = 36'sh000000007;
         5'd28: a = 36'sh000000003;
         5'd29: a = 36'sh000000001;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/qrvu_req_if.sv -----
// qrvu_req_if: request channel, valid/ready with rotation vector and load fields
// depends on nothing
`default_nettype none

interface qrvu_req_if;
   logic               valid;
   logic               ready;
   logic               op;
   logic signed [31:0] rot_x;
   logic signed [31:0] rot_y;
   logic signed [31:0] rot_z;
   logic signed [31:0] load_w;
   logic signed [31:0] load_x;
   logic signed [31:0] load_y;
   logic signed [31:0] load_z;

   modport source (output valid, op, rot_x, rot_y, rot_z, load_w, load_x, load_y, load_z,
                   input ready);
   modport sink   (input valid, op, rot_x, rot_y, rot_z, load_w, load_x, load_y, load_z,
                   output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/qrvu_rsp_if.sv -----
// qrvu_rsp_if: response channel, valid/ready with the updated quaternion
// depends on nothing
`default_nettype none

interface qrvu_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] quat_w;
   logic signed [31:0] quat_x;
   logic signed [31:0] quat_y;
   logic signed [31:0] quat_z;

   modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
   modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/qrvu_ctrl.sv -----
// qrvu_ctrl: sequencer for sum of squares, square root, divide/cordic and multiply phases
// depends on qrvu_pkg
`default_nettype none

module qrvu_ctrl import qrvu_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_op,
   output logic            req_ready,
   input  wire logic       rsp_ready,
   output logic            rsp_valid,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_SUMSQ, S_SQRT, S_SETUP, S_DIVC, S_FIN, S_IMAG, S_QMUL, S_WRITE, S_OUT
   } state_type;

   localparam logic [STEP_W-1:0] SUMSQ_LAST = 5'd2;
   localparam logic [STEP_W-1:0] SQRT_LAST  = 5'd31;
   localparam logic [STEP_W-1:0] DIVC_LAST  = 5'd30;
   localparam logic [STEP_W-1:0] IMAG_LAST  = 5'd3;
   localparam logic [STEP_W-1:0] QMUL_LAST  = 5'd16;

   state_type         state_ff;
   logic [STEP_W-1:0] step_ff;
   logic              rsp_valid_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      cmd.step = step_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.start = req_valid;
            cmd.load  = (op_type'(req_op) == OP_LOAD);
         end
         S_SUMSQ: cmd.sumsq     = 1'b1;
         S_SQRT:  cmd.sqrt_step = 1'b1;
         S_SETUP: begin
            cmd.inc_zero = status.angle_zero;
            cmd.div_init = !status.angle_zero;
         end
         S_DIVC:  cmd.divc_step = 1'b1;
         S_FIN:   cmd.inc_set   = 1'b1;
         S_IMAG:  cmd.mul_go    = (step_ff < IMAG_LAST);
         S_QMUL: begin
            cmd.mul_go   = (step_ff < QMUL_LAST);
            cmd.mul_quat = 1'b1;
         end
         S_WRITE: cmd.commit   = 1'b1;
         S_OUT:   cmd.out_load = !rsp_valid_ff || rsp_ready;
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         step_ff <= step_ff + 5'd1;
         unique case (state_ff)
            S_IDLE: begin
               step_ff <= '0;
               if (req_valid) begin
                  state_ff <= (op_type'(req_op) == OP_LOAD) ? S_OUT : S_SUMSQ;
               end
            end
            S_SUMSQ: begin
               if (step_ff == SUMSQ_LAST) begin
                  state_ff <= S_SQRT;
                  step_ff  <= '0;
               end
            end
            S_SQRT: begin
               if (step_ff == SQRT_LAST) begin
                  state_ff <= S_SETUP;
                  step_ff  <= '0;
               end
            end
            S_SETUP: begin
               step_ff  <= '0;
               state_ff <= status.angle_zero ? S_QMUL : S_DIVC;
            end
            S_DIVC: begin
               if (step_ff == DIVC_LAST) begin
                  state_ff <= S_FIN;
                  step_ff  <= '0;
               end
            end
            S_FIN: begin
               state_ff <= S_IMAG;
               step_ff  <= '0;
            end
            S_IMAG: begin
               if (step_ff == IMAG_LAST) begin
                  state_ff <= S_QMUL;
                  step_ff  <= '0;
               end
            end
            S_QMUL: begin
               if (step_ff == QMUL_LAST) begin
                  state_ff <= S_WRITE;
                  step_ff  <= '0;
               end
            end
            S_WRITE: begin
               state_ff <= S_OUT;
               step_ff  <= '0;
            end
            S_OUT: begin
               step_ff <= '0;
               if (cmd.out_load) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/qrvu_datapath.sv -----
// qrvu_datapath: square root, three dividers, cordic, shared multiplier and attitude state
// depends on qrvu_pkg
`default_nettype none

module qrvu_datapath import qrvu_pkg::*; #(
   parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cmd_type            cmd,
   output status_type              status,
   input  wire logic signed [31:0] rot_x,
   input  wire logic signed [31:0] rot_y,
   input  wire logic signed [31:0] rot_z,
   input  wire logic signed [31:0] load_w,
   input  wire logic signed [31:0] load_x,
   input  wire logic signed [31:0] load_y,
   input  wire logic signed [31:0] load_z,
   output logic signed [31:0]      quat_w,
   output logic signed [31:0]      quat_x,
   output logic signed [31:0]      quat_y,
   output logic signed [31:0]      quat_z
);

   localparam int AW    = (WORD_WIDTH > 32) ? WORD_WIDTH : 32;
   localparam int ACC_W = AW + 4;
   localparam int PW    = AW + INC_W;

   localparam logic signed [ACC_W-1:0] SAT_HI = (ACC_W'(1) <<< (WORD_WIDTH - 1)) - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

   function automatic logic signed [WORD_WIDTH-1:0] sat_word(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI;
      end else if (v < SAT_LO) begin
         r = SAT_LO;
      end else begin
         r = v;
      end
      return r[WORD_WIDTH-1:0];
   endfunction

   logic [31:0]                   mag_ff [3];
   logic                          nneg_ff [3];
   logic [63:0]                   sq_v_ff, sq_res_ff, sq_bit_ff;
   logic [31:0]                   div_r_ff [3];
   logic [30:0]                   div_q_ff [3];
   logic signed [CORDIC_W-1:0]    cx_ff, cy_ff, cz_ff;
   logic                          cneg_ff;
   logic signed [INC_W-1:0]       c_ff;
   logic signed [INC_W-1:0]       imag_ff [3];
   logic signed [WORD_WIDTH-1:0]  att_ff [4];
   logic signed [ACC_W-1:0]       acc_ff [4];
   logic signed [PW-1:0]          prod_ff;
   logic                          pvld_ff, pquat_ff, pneg_ff;
   logic [3:0]                    pidx_ff;
   logic signed [31:0]            out_ff [4];

   logic [31:0]                   angle;
   logic [31:0]                   sq_mag;
   logic [63:0]                   sq_t;
   logic signed [CORDIC_W-1:0]    th0, th1, th2;
   logic                          th_neg;
   logic signed [CORDIC_W-1:0]    s_full, c_full, dx, dy;
   logic signed [AW-1:0]          mul_a;
   logic signed [INC_W-1:0]       mul_b;
   logic signed [31:0]            ax;
   logic [30:0]                   ax_q;
   logic                          ax_neg;
   term_type                      term;
   logic signed [PW-1:0]          prod_sh;
   logic signed [ACC_W-1:0]       shv;
   logic signed [31:0]            load_v [4];

   assign angle             = sq_res_ff[31:0];
   assign status.angle_zero = (sq_res_ff == 64'd0);
   assign sq_t              = sq_res_ff + sq_bit_ff;
   assign load_v            = '{load_w, load_x, load_y, load_z};

   always_comb begin
      unique case (cmd.step[1:0])
         2'd0:    sq_mag = mag_ff[0];
         2'd1:    sq_mag = mag_ff[1];
         2'd2:    sq_mag = mag_ff[2];
         default: sq_mag = '0;
      endcase
   end

   // half angle reduction into [-pi/2, pi/2]
   always_comb begin
      th0    = CORDIC_W'({angle, 1'b0});
      th1    = (th0 > PI_Q30) ? th0 - TWO_PI_Q30 : th0;
      th_neg = 1'b0;
      th2    = th1;
      if (th1 > HALF_PI_Q30) begin
         th2    = th1 - PI_Q30;
         th_neg = 1'b1;
      end else if (th1 < -HALF_PI_Q30) begin
         th2    = th1 + PI_Q30;
         th_neg = 1'b1;
      end
   end

   assign dx     = cy_ff >>> cmd.step;
   assign dy     = cx_ff >>> cmd.step;
   assign s_full = cneg_ff ? -cy_ff : cy_ff;
   assign c_full = cneg_ff ? -cx_ff : cx_ff;

   // multiplier operand selection
   always_comb begin
      term = qr_term(cmd.step[3:0]);
      unique case (cmd.step[1:0])
         2'd0:    begin ax_q = div_q_ff[0]; ax_neg = nneg_ff[0]; end
         2'd1:    begin ax_q = div_q_ff[1]; ax_neg = nneg_ff[1]; end
         2'd2:    begin ax_q = div_q_ff[2]; ax_neg = nneg_ff[2]; end
         default: begin ax_q = '0; ax_neg = 1'b0; end
      endcase
      ax = ax_neg ? -signed'({1'b0, ax_q}) : signed'({1'b0, ax_q});
      if (cmd.mul_quat) begin
         mul_a = AW'(att_ff[term.att]);
         unique case (term.inc)
            2'd0:    mul_b = c_ff;
            2'd1:    mul_b = imag_ff[0];
            2'd2:    mul_b = imag_ff[1];
            default: mul_b = imag_ff[2];
         endcase
      end else begin
         mul_a = AW'(ax);
         mul_b = INC_W'(s_full);
      end
   end

   assign prod_sh = prod_ff >>> FRAC_BITS;
   assign shv     = ACC_W'(prod_sh);

   always_ff @(posedge clock) begin
      if (reset) begin
         pvld_ff <= 1'b0;
      end else begin
         pvld_ff <= cmd.mul_go;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         att_ff[0] <= sat_word(ACC_W'(ONE_Q30));
         att_ff[1] <= '0;
         att_ff[2] <= '0;
         att_ff[3] <= '0;
      end else if (cmd.start && cmd.load) begin
         for (int i = 0; i < 4; i++) begin
            att_ff[i] <= sat_word(ACC_W'(load_v[i]));
         end
      end else if (cmd.commit) begin
         for (int i = 0; i < 4; i++) begin
            att_ff[i] <= sat_word(acc_ff[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start && !cmd.load) begin
         mag_ff[0]  <= rot_x[31] ? 32'(-rot_x) : 32'(rot_x);
         mag_ff[1]  <= rot_y[31] ? 32'(-rot_y) : 32'(rot_y);
         mag_ff[2]  <= rot_z[31] ? 32'(-rot_z) : 32'(rot_z);
         nneg_ff[0] <= rot_x[31];
         nneg_ff[1] <= rot_y[31];
         nneg_ff[2] <= rot_z[31];
         sq_v_ff    <= '0;
         sq_res_ff  <= '0;
         sq_bit_ff  <= 64'd1 << 62;
         for (int i = 0; i < 4; i++) begin
            acc_ff[i] <= '0;
         end
      end
      if (cmd.sumsq) begin
         sq_v_ff <= sq_v_ff + 64'(sq_mag) * 64'(sq_mag);
      end
      if (cmd.sqrt_step) begin
         if (sq_v_ff >= sq_t) begin
            sq_v_ff   <= sq_v_ff - sq_t;
            sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
         end else begin
            sq_res_ff <= sq_res_ff >> 1;
         end
         sq_bit_ff <= sq_bit_ff >> 2;
      end
      if (cmd.div_init) begin
         for (int i = 0; i < 3; i++) begin
            div_r_ff[i] <= mag_ff[i] >> 1;
            div_q_ff[i] <= '0;
         end
         cx_ff   <= CORDIC_GAIN;
         cy_ff   <= '0;
         cz_ff   <= th2;
         cneg_ff <= th_neg;
      end
      if (cmd.divc_step) begin
         for (int i = 0; i < 3; i++) begin
            logic [32:0] r2;
            r2 = {div_r_ff[i], (cmd.step == '0) ? mag_ff[i][0] : 1'b0};
            if (r2 >= {1'b0, angle}) begin
               div_r_ff[i] <= 32'(r2 - {1'b0, angle});
               div_q_ff[i] <= {div_q_ff[i][29:0], 1'b1};
            end else begin
               div_r_ff[i] <= r2[31:0];
               div_q_ff[i] <= {div_q_ff[i][29:0], 1'b0};
            end
         end
         if (cmd.step < STEP_W'(CORDIC_ITERS)) begin
            if (cz_ff >= 0) begin
               cx_ff <= cx_ff - dx;
               cy_ff <= cy_ff + dy;
               cz_ff <= cz_ff - atan_q30(cmd.step);
            end else begin
               cx_ff <= cx_ff + dx;
               cy_ff <= cy_ff - dy;
               cz_ff <= cz_ff + atan_q30(cmd.step);
            end
         end
      end
      if (cmd.inc_set) begin
         c_ff <= INC_W'(c_full);
      end
      if (cmd.inc_zero) begin
         c_ff <= ONE_Q30;
         for (int i = 0; i < 3; i++) begin
            imag_ff[i] <= '0;
         end
      end
      if (cmd.mul_go) begin
         prod_ff  <= PW'(mul_a) * PW'(mul_b);
         pquat_ff <= cmd.mul_quat;
         pneg_ff  <= cmd.mul_quat && term.neg;
         pidx_ff  <= cmd.step[3:0];
      end
      if (pvld_ff) begin
         if (pquat_ff) begin
            acc_ff[pidx_ff[3:2]] <= pneg_ff ? acc_ff[pidx_ff[3:2]] - shv
                                            : acc_ff[pidx_ff[3:2]] + shv;
         end else begin
            unique case (pidx_ff[1:0])
               2'd0:    imag_ff[0] <= INC_W'(shv);
               2'd1:    imag_ff[1] <= INC_W'(shv);
               2'd2:    imag_ff[2] <= INC_W'(shv);
               default: ;
            endcase
         end
      end
      if (cmd.out_load) begin
         for (int i = 0; i < 4; i++) begin
            logic signed [AW-1:0] e;
            e = AW'(att_ff[i]);
            out_ff[i] <= e[31:0];
         end
      end
   end

   assign quat_w = out_ff[0];
   assign quat_x = out_ff[1];
   assign quat_y = out_ff[2];
   assign quat_z = out_ff[3];

endmodule

`default_nettype wire

// ----- hw/rtl/quaternion_rotation_vector_update.sv -----
// quaternion_rotation_vector_update: top level, attitude integrator from rotation vectors
// depends on qrvu_pkg, qrvu_req_if, qrvu_rsp_if, qrvu_ctrl, qrvu_datapath
//
// Keeps an attitude quaternion (Q2.30, reset to identity) and returns the new attitude
// for every request. A load request (op 1) goes from acceptance straight to the output.
// An apply request (op 0) runs the sum of the three squares through one
// 32x32 multiplier, then the bit-pair square root, then the three lane dividers
// that run beside the 30-step cordic, and then the shared multiplier that forms the
// axis sine terms and the 16 quaternion products. A zero vector skips divide and cordic.
// One request is in work at a time; the response register lets the next request be
// accepted while a response still waits.
`default_nettype none

module quaternion_rotation_vector_update import qrvu_pkg::*; #(
   parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   qrvu_req_if.sink   req,
   qrvu_rsp_if.source rsp
);

   cmd_type    cmd;
   status_type status;

   qrvu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_op    (req.op),
      .req_ready (req.ready),
      .rsp_ready (rsp.ready),
      .rsp_valid (rsp.valid),
      .status    (status),
      .cmd       (cmd)
   );

   qrvu_datapath #(
      .WORD_WIDTH (WORD_WIDTH)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .status (status),
      .rot_x  (req.rot_x),
      .rot_y  (req.rot_y),
      .rot_z  (req.rot_z),
      .load_w (req.load_w),
      .load_x (req.load_x),
      .load_y (req.load_y),
      .load_z (req.load_z),
      .quat_w (rsp.quat_w),
      .quat_x (rsp.quat_x),
      .quat_y (rsp.quat_y),
      .quat_z (rsp.quat_z)
   );

endmodule

`default_nettype wire

// ----- sim/qrvu_checker.sv -----
// qrvu_checker: watches the request and response channels, predicts the attitude
// depends on qrvu_pkg, qrvu_req_if, qrvu_rsp_if
`default_nettype none

module qrvu_checker import qrvu_pkg::*; #(
   parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   qrvu_req_if       req,
   qrvu_rsp_if       rsp,
   output int        fail_count,
   output int        pending,
   output int        rsp_count
);

   typedef struct {
      logic signed [31:0] w, x, y, z;
   } quat_t;

   quat_t att_q[$];
   longint att_w, att_v[3];

   localparam longint ATAN[30] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
      64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
      64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
      64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
      64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000007, 64'h00000003, 64'h00000001};

   function automatic longint sat_w(longint v);
      longint hi;
      hi = (longint'(1) <<< (WORD_WIDTH - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   function automatic longint qmul(longint a, longint b);
      return (a * b) >>> FRAC_BITS;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   task automatic half_sin_cos(input longint th, output longint s, output longint c);
      bit neg;
      longint x, y, dx, dy;
      neg = 0;
      x = 652032874;
      y = 0;
      if (th > 64'sd3373259426) th -= 64'sd6746518852;
      if (th > 64'sd1686629713) begin
         th -= 64'sd3373259426;
         neg = 1;
      end else if (th < -64'sd1686629713) begin
         th += 64'sd3373259426;
         neg = 1;
      end
      for (int i = 0; i < 30; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (th >= 0) begin
            x -= dx; y += dy; th -= ATAN[i];
         end else begin
            x += dx; y -= dy; th += ATAN[i];
         end
      end
      c = neg ? -x : x;
      s = neg ? -y : y;
   endtask

   task automatic predict_attitude();
      longint n[3], im[3], c, s, w, v[3], nv[3], ax;
      longint unsigned mag[3], sum, ang;
      quat_t q;
      if (req.op == OP_LOAD) begin
         att_w = sat_w(longint'(req.load_w));
         att_v[0] = sat_w(longint'(req.load_x));
         att_v[1] = sat_w(longint'(req.load_y));
         att_v[2] = sat_w(longint'(req.load_z));
      end else begin
         n[0] = req.rot_x; n[1] = req.rot_y; n[2] = req.rot_z;
         sum = 0;
         for (int i = 0; i < 3; i++) begin
            mag[i] = n[i] < 0 ? -n[i] : n[i];
            sum += mag[i] * mag[i];
         end
         ang = int_sqrt(sum);
         if (ang == 0) begin
            c = longint'(1) <<< FRAC_BITS;
            im = '{0, 0, 0};
         end else begin
            half_sin_cos(longint'(ang << 1), s, c);
            for (int i = 0; i < 3; i++) begin
               ax = longint'((mag[i] << FRAC_BITS) / ang);
               if (n[i] < 0) ax = -ax;
               im[i] = qmul(ax, s);
            end
         end
         w = att_w;
         v = att_v;
         nv[0] = qmul(c, v[0]) + qmul(w, im[0]) + qmul(im[1], v[2]) - qmul(im[2], v[1]);
         nv[1] = qmul(c, v[1]) + qmul(w, im[1]) + qmul(im[2], v[0]) - qmul(im[0], v[2]);
         nv[2] = qmul(c, v[2]) + qmul(w, im[2]) + qmul(im[0], v[1]) - qmul(im[1], v[0]);
         att_w = sat_w(qmul(c, w) - qmul(im[0], v[0]) - qmul(im[1], v[1])
                       - qmul(im[2], v[2]));
         for (int i = 0; i < 3; i++) att_v[i] = sat_w(nv[i]);
      end
      q.w = att_w[31:0]; q.x = att_v[0][31:0]; q.y = att_v[1][31:0]; q.z = att_v[2][31:0];
      att_q.push_back(q);
   endtask

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
      $display("mismatch %s: got %h expected %h", what, got, exp);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      rsp_count = 0;
   end

   assign pending = att_q.size();

   always @(posedge clock) begin
      quat_t e;
      if (reset) begin
         att_w = sat_w(longint'(1) <<< FRAC_BITS);
         att_v = '{0, 0, 0};
      end else begin
         if (rsp.valid && rsp.ready) begin
            rsp_count++;
            if (att_q.size() == 0) begin
               report("unexpected response", rsp.quat_w, 0);
            end else begin
               e = att_q.pop_front();
               if (rsp.quat_w !== e.w) report("quat_w", rsp.quat_w, e.w);
               if (rsp.quat_x !== e.x) report("quat_x", rsp.quat_x, e.x);
               if (rsp.quat_y !== e.y) report("quat_y", rsp.quat_y, e.y);
               if (rsp.quat_z !== e.z) report("quat_z", rsp.quat_z, e.z);
            end
         end
         if (req.valid && req.ready) predict_attitude();
      end
   end

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// tb: stimulus and verdict for quaternion_rotation_vector_update
// depends on qrvu_pkg, qrvu_req_if, qrvu_rsp_if, qrvu_checker and the block itself
`default_nettype none

module tb;
   import qrvu_pkg::*;

   localparam int N_RANDOM = 830;
   localparam int WATCHDOG = 20000;

   logic clock = 0;
   logic reset = 1;
   int   fail_count, pending, rsp_count;
   int   idle_cycles = 0;
   int   rsp_gap = 0;
   int   n_apply = 0, n_load = 0;

   qrvu_req_if req ();
   qrvu_rsp_if rsp ();

   quaternion_rotation_vector_update DUT (.clock(clock), .reset(reset), .req(req), .rsp(rsp));
   qrvu_checker CHK (.clock(clock), .reset(reset), .req(req), .rsp(rsp),
                     .fail_count(fail_count), .pending(pending), .rsp_count(rsp_count));

   always #2 clock = ~clock;

   initial begin
      req.valid = 0; req.op = OP_APPLY;
      req.rot_x = 0; req.rot_y = 0; req.rot_z = 0;
      req.load_w = 0; req.load_x = 0; req.load_y = 0; req.load_z = 0;
      rsp.ready = 0;
   end

   function automatic int gap_len();
      if ($urandom_range(0, 3) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
      return $urandom_range(0, 4);
   endfunction

   function automatic logic [31:0] rand_rot();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'(int'($urandom_range(0, 4000)) - 2000);
         2: return {{5{$urandom_range(0, 1) == 1}}, 27'($urandom)};
         default: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
      endcase
   endfunction

   task automatic send(input op_type op, input logic [31:0] rx, ry, rz,
                       input logic [31:0] lw, lx, ly, lz);
      int g;
      g = gap_len();
      if (g > 0) begin
         req.valid <= 0;
         repeat (g) @(posedge clock);
      end
      req.valid <= 1;
      req.op <= op;
      req.rot_x <= rx; req.rot_y <= ry; req.rot_z <= rz;
      req.load_w <= lw; req.load_x <= lx; req.load_y <= ly; req.load_z <= lz;
      if (op == OP_LOAD) n_load++; else n_apply++;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   task automatic send_unit_load();
      send(OP_LOAD, $urandom, $urandom, $urandom, 32'sd1 << 30, 0, 0, 0);
   endtask

   // response side: ready for one cycle, then a random stall that may be empty
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 0;
         rsp_gap <= 0;
      end else if (rsp_gap > 0) begin
         rsp.ready <= 0;
         rsp_gap <= rsp_gap - 1;
      end else begin
         rsp.ready <= 1;
         rsp_gap <= gap_len();
      end
   end

   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("watchdog expired with %0d responses outstanding", pending);
         $display("** quaternion_rotation_vector_update: FAILED **");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: zero vector, extremes, pi wrap, loads
      send(OP_APPLY, 0, 0, 0, $urandom, $urandom, $urandom, $urandom);
      send(OP_APPLY, 32'h7FFFFFFF, 0, 0, 0, 0, 0, 0);
      send(OP_APPLY, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 0);
      send(OP_APPLY, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0, 0);
      send(OP_APPLY, 1, 0, 0, 0, 0, 0, 0);
      send(OP_APPLY, 0, 32'hFFFFFFFF, 0, 0, 0, 0, 0);
      send(OP_APPLY, 0, 0, 32'h3243F6A9, 0, 0, 0, 0);
      send(OP_APPLY, 32'h1921FB54, 32'hE6DE04AC, 0, 0, 0, 0, 0);
      send(OP_LOAD, 0, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      send(OP_APPLY, 32'h10000000, 32'h10000000, 32'h10000000, 0, 0, 0, 0);
      send(OP_LOAD, 0, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
      send(OP_APPLY, 32'hF0000000, 32'h20000000, 32'h05000000, 0, 0, 0, 0);
      send(OP_LOAD, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 0, 0);
      send(OP_APPLY, 32'h00400000, 32'hFFC00000, 32'h00200000, 0, 0, 0, 0);
      send_unit_load();
      send(OP_APPLY, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 0);
      send(OP_APPLY, 0, 0, 0, 0, 0, 0, 0);
      // random: mostly small rotations, some loads
      for (int k = 0; k < N_RANDOM; k++) begin
         if ($urandom_range(0, 39) == 0) send_unit_load();
         else if ($urandom_range(0, 9) == 0)
            send(OP_LOAD, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         else if ($urandom_range(0, 29) == 0)
            send(OP_APPLY, 0, 0, 0, $urandom, $urandom, $urandom, $urandom);
         else
            send(OP_APPLY, rand_rot(), rand_rot(), rand_rot(),
                 $urandom, $urandom, $urandom, $urandom);
      end
      req.valid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("covered %0d apply and %0d load requests, %0d responses checked",
               n_apply, n_load, rsp_count);
      if (fail_count == 0 && pending == 0) begin
         $display("** quaternion_rotation_vector_update: PASSED **");
      end else begin
         $display("** quaternion_rotation_vector_update: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire
